// File: hw/rtl/stack_machine_step_macros.svh
// Assertion macros used by the stack processor top level RTL file.
`ifndef STACK_MACHINE_STEP_MACROS_SVH
`define STACK_MACHINE_STEP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sms_pkg.sv
// Package: sizes, opcodes, request and status codes of the stack processor.
`default_nettype none
package sms_pkg;
  localparam int PROGRAM_DEPTH = 256;
  localparam int STACK_DEPTH   = 128;
  localparam int WORD_WIDTH    = 32;
  localparam int PA_W  = $clog2(PROGRAM_DEPTH);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Request types
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_STEP    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Opcodes (whole word is decoded)
  localparam logic [WORD_WIDTH-1:0] OP_HALT = WORD_WIDTH'(0);
  localparam logic [WORD_WIDTH-1:0] OP_PUSH = WORD_WIDTH'(1);
  localparam logic [WORD_WIDTH-1:0] OP_POP  = WORD_WIDTH'(2);
  localparam logic [WORD_WIDTH-1:0] OP_ADD  = WORD_WIDTH'(3);
  localparam logic [WORD_WIDTH-1:0] OP_SUB  = WORD_WIDTH'(4);
  localparam logic [WORD_WIDTH-1:0] OP_MOD  = WORD_WIDTH'(5);
  localparam logic [WORD_WIDTH-1:0] OP_BR   = WORD_WIDTH'(16);
  localparam logic [WORD_WIDTH-1:0] OP_BNZ  = WORD_WIDTH'(17);
  localparam logic [WORD_WIDTH-1:0] OP_BZ   = WORD_WIDTH'(18);
  localparam logic [WORD_WIDTH-1:0] OP_RET  = WORD_WIDTH'(19);
  localparam logic [WORD_WIDTH-1:0] OP_SWAP = WORD_WIDTH'(30);
  localparam logic [WORD_WIDTH-1:0] OP_CMP  = WORD_WIDTH'(31);
endpackage
`default_nettype wire

// File: hw/rtl/sms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/sms_rem.sv
// Iterative signed remainder unit, one quotient bit per cycle.
`default_nettype none
module sms_rem (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [sms_pkg::WORD_WIDTH-1:0]  dividend,
  input  wire logic [sms_pkg::WORD_WIDTH-1:0]  divisor,
  output logic                                 done,
  output logic [sms_pkg::WORD_WIDTH-1:0]       result
);
  import sms_pkg::*;

  localparam int IT_W = $clog2(WORD_WIDTH);

  logic                  busy;
  logic [IT_W-1:0]       cnt;
  logic [WORD_WIDTH-1:0] dvd;
  logic [WORD_WIDTH-1:0] mb;
  logic [WORD_WIDTH-1:0] rem;
  logic                  neg;
  logic [WORD_WIDTH:0]   sh;
  logic [WORD_WIDTH:0]   trial;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    sh    = {rem, dvd[WORD_WIDTH-1]};
    trial = (sh >= {1'b0, mb}) ? (sh - {1'b0, mb}) : sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= IT_W'(WORD_WIDTH - 1);
        dvd  <= dividend[WORD_WIDTH-1] ? (~dividend + 1'b1) : dividend;
        mb   <= divisor[WORD_WIDTH-1] ? (~divisor + 1'b1) : divisor;
        neg  <= dividend[WORD_WIDTH-1];
        rem  <= '0;
      end else if (busy) begin
        rem <= trial[WORD_WIDTH-1:0];
        dvd <= {dvd[WORD_WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder takes the sign of the dividend
  assign result = neg ? (~rem + 1'b1) : rem;
endmodule
`default_nettype wire

// File: hw/rtl/stack_machine_step.sv
// Top level: sequencer of the stack processor with program and stack memories.
//
//  channel | direction | handshake            | beat payload
//  req     | in        | req_valid/req_stall  | req_type, load_address, load_word
//  rsp     | out       | rsp_valid/rsp_stall  | halted, next_pc, top_value, stack_count,
//          |           |                      | opcode_done, status
//
// Load, restart, halted, unused requests go via top and final states to a result beat.
// A step adds fetch and opcode states; mod waits on the bit-serial remainder unit.
// Each cycle moves at most one word through the stack memory's single read port.
// Reset (rst, synchronous) empties the stack, zeroes pc and link, sets running.
// req_stall is high while an item is in work; a stalled result beat holds the
// sequencer in its final state.
`default_nettype none
`include "stack_machine_step_macros.svh"
module stack_machine_step (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic [1:0]                       req_type,
  input  wire logic [7:0]                       load_address,
  input  wire logic [31:0]                      load_word,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output logic                                  halted,
  output logic [7:0]                            next_pc,
  output logic signed [31:0]                    top_value,
  output logic [7:0]                            stack_count,
  output logic [7:0]                            opcode_done,
  output logic [1:0]                            status
);
  import sms_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_IMM   = 4'd2;
  localparam logic [3:0] S_RDA   = 4'd3;
  localparam logic [3:0] S_RDB   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WR2   = 4'd6;
  localparam logic [3:0] S_TOP   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]            state;
  logic [PA_W-1:0]       pc;
  logic [PA_W-1:0]       link;
  logic                  running;
  logic [CNT_W-1:0]      count;
  logic [WORD_WIDTH-1:0] op;
  logic [WORD_WIDTH-1:0] a;
  logic [WORD_WIDTH-1:0] imm;
  logic [1:0]            stat;
  logic                  executed;

  logic                  accept;
  logic [WORD_WIDTH-1:0] prog_rdata;
  logic [WORD_WIDTH-1:0] stk_rdata;
  logic [SA_W-1:0]       stk_raddr;
  logic                  stk_we;
  logic [SA_W-1:0]       stk_waddr;
  logic [WORD_WIDTH-1:0] stk_wdata;
  logic [CNT_W-1:0]      cm1;
  logic [CNT_W-1:0]      cm2;
  logic [SA_W-1:0]       sa_top;
  logic [SA_W-1:0]       sa_second;
  logic [SA_W-1:0]       sa_swap;
  logic                  rem_start;
  logic                  rem_done;
  logic [WORD_WIDTH-1:0] rem_result;
  logic                  cond_zero;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // Stack addresses derived from the count
  assign cm1       = count - CNT_W'(1);
  assign cm2       = count - CNT_W'(2);
  assign sa_top    = cm1[SA_W-1:0];
  assign sa_second = cm2[SA_W-1:0];
  assign sa_swap   = sa_top - imm[SA_W-1:0];
  assign cond_zero = (stk_rdata == '0);

  // Program memory: written by load beats, always read at pc
  sms_ram #(.WIDTH(WORD_WIDTH), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (accept && (req_type == REQ_LOAD)),
    .waddr (load_address[PA_W-1:0]),
    .wdata (WORD_WIDTH'(load_word)),
    .raddr (pc),
    .rdata (prog_rdata)
  );

  // Operand stack memory
  sms_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Remainder unit for mod
  sms_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (a),
    .divisor  (stk_rdata),
    .done     (rem_done),
    .result   (rem_result)
  );

  // Stack read address: in operand read, swap partner or entry below top; else the top
  assign stk_raddr = (state == S_RDA) ? ((op == OP_SWAP) ? sa_swap : sa_second) : sa_top;
  assign rem_start = (state == S_RDB) && (op == OP_MOD) && !cond_zero && (count >= CNT_W'(2));

  // Stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sa_top;
    stk_wdata = stk_rdata;
    unique case (state)
      S_IMM: begin
        stk_we    = (op == OP_PUSH) && (count < CNT_W'(STACK_DEPTH));
        stk_waddr = count[SA_W-1:0];
        stk_wdata = prog_rdata;
      end
      S_RDB: begin
        if (op == OP_ADD || op == OP_SUB || op == OP_MOD) begin
          stk_we    = (op != OP_MOD) || cond_zero;
          stk_waddr = sa_second;
          stk_wdata = (op == OP_ADD) ? (a + stk_rdata) :
                      (op == OP_SUB) ? (a - stk_rdata) : '0;
        end else if (op == OP_CMP) begin
          stk_we    = 1'b1;
          stk_waddr = count[SA_W-1:0];
          stk_wdata = (a == stk_rdata) ? WORD_WIDTH'(1) : '0;
        end else if (op == OP_SWAP) begin
          stk_we    = 1'b1;
          stk_waddr = sa_top;
          stk_wdata = stk_rdata;
        end
      end
      S_WR2: begin
        stk_we    = 1'b1;
        stk_waddr = sa_swap;
        stk_wdata = a;
      end
      S_DIV: begin
        stk_we    = rem_done;
        stk_waddr = sa_second;
        stk_wdata = rem_result;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      link      <= '0;
      running   <= 1'b1;
      count     <= '0;
      op        <= '0;
      rsp_valid <= 1'b0;
      stat      <= ST_OK;
      executed  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            stat     <= ST_OK;
            executed <= 1'b0;
            state    <= S_TOP;
            if (req_type == REQ_RESTART) begin
              pc      <= '0;
              count   <= '0;
              running <= 1'b1;
            end else if (req_type == REQ_STEP && running) begin
              executed <= 1'b1;
              pc       <= pc + 1'b1;
              state    <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          op    <= prog_rdata;
          state <= S_TOP;
          case (prog_rdata)
            OP_HALT: running <= 1'b0;
            OP_PUSH, OP_SWAP: begin
              pc    <= pc + 1'b1;
              state <= S_IMM;
            end
            OP_POP: begin
              if (count == '0) stat <= ST_UNDER;
              else count <= cm1;
            end
            OP_ADD, OP_SUB, OP_MOD, OP_CMP: begin
              if (count < CNT_W'(2)) stat <= ST_UNDER;
              else if (prog_rdata == OP_CMP && count >= CNT_W'(STACK_DEPTH)) stat <= ST_OVER;
              else state <= S_RDA;
            end
            OP_BR, OP_BNZ, OP_BZ: begin
              link <= pc;
              if (count == '0) stat <= ST_UNDER;
              else state <= S_RDA;
            end
            OP_RET: pc <= link;
            default: ;
          endcase
        end
        S_IMM: begin
          imm   <= prog_rdata;
          state <= S_TOP;
          if (op == OP_PUSH) begin
            if (count >= CNT_W'(STACK_DEPTH)) stat <= ST_OVER;
            else count <= count + CNT_W'(1);
          end else if (prog_rdata >= WORD_WIDTH'(count)) begin
            stat <= ST_UNDER;
          end else begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          a     <= stk_rdata;
          state <= S_RDB;
          if (op == OP_BR) begin
            count <= cm1;
            pc    <= stk_rdata[PA_W-1:0];
            state <= S_TOP;
          end else if (op == OP_BNZ || op == OP_BZ) begin
            if ((op == OP_BNZ) == cond_zero) begin
              count <= cm1;
              state <= S_TOP;
            end else if (count < CNT_W'(2)) begin
              stat  <= ST_UNDER;
              state <= S_TOP;
            end
          end
        end
        S_RDB: begin
          state <= S_TOP;
          case (op)
            OP_BNZ, OP_BZ: begin
              count <= cm2;
              pc    <= stk_rdata[PA_W-1:0];
            end
            OP_ADD, OP_SUB: count <= cm1;
            OP_MOD: begin
              if (cond_zero) begin
                count <= cm1;
                stat  <= ST_DIVZ;
              end else begin
                state <= S_DIV;
              end
            end
            OP_CMP:  count <= count + CNT_W'(1);
            OP_SWAP: state <= S_WR2;
            default: ;
          endcase
        end
        S_WR2: state <= S_TOP;
        S_DIV: begin
          if (rem_done) begin
            count <= cm1;
            state <= S_TOP;
          end
        end
        S_TOP: state <= S_FIN;
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            halted      <= !running;
            next_pc     <= 8'(pc);
            top_value   <= (count != '0) ? 32'(signed'(stk_rdata)) : '0;
            stack_count <= 8'(count);
            opcode_done <= executed ? op[7:0] : 8'd0;
            status      <= stat;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `SMS_ASSERT_NEXT(a_step_fetch, accept && req_type == REQ_STEP && running, state == S_FETCH, "step did not fetch")
  `SMS_ASSERT_NOW(a_rsp_from_fin, $rose(rsp_valid), $past(state) == S_FIN, "result beat outside final state")
  `SMS_ASSERT_NOW(a_div_hold, state == S_DIV, op == OP_MOD, "remainder wait without mod")
endmodule
`default_nettype wire
